// ===== hdl/lzss_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LZSS stream decompressor.
package lzss_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int LANES             = 4;   // bytes packed into one result word
    localparam int NEAR_WINDOW       = 4;   // match offsets served from the recent-byte window
    localparam int TOKENS_PER_BLOCK  = 8;
    localparam int HEADER_LAST       = 7;   // index of the final header byte
    localparam int CMDQ_DEPTH        = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        run_last;
        logic        bad_match;
        logic        stream_done;
    } out_word_t;

    // One unit of work handed from the parser to the copy engine.
    typedef struct packed {
        logic        is_lit;
        logic [7:0]  lit;
        logic [15:0] off;
        logic [7:0]  cnt;    // bytes to produce; zero means status only
        logic        bad;
        logic        eos;
    } cmd_t;

endpackage

// ===== hdl/lzss_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lzss_cmdq.sv =====
`timescale 1ns / 1ps
// Short command queue between the parser and the copy engine.
module lzss_cmdq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lzss_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output lzss_pkg::cmd_t head
);

    localparam int AW = $clog2(lzss_pkg::CMDQ_DEPTH);

    lzss_pkg::cmd_t entry_reg [lzss_pkg::CMDQ_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(lzss_pkg::CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command queue pushed while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("command queue popped while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(lzss_pkg::CMDQ_DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

// ===== hdl/lzss_front.sv =====
`timescale 1ns / 1ps
// Stream parser: header, flag bytes and tokens into copy commands.
module lzss_front #(
    parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lzss_pkg::in_word_t s_data,
    output logic               cmd_push,
    output lzss_pkg::cmd_t     cmd_data,
    input  logic               cmd_full
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_FLAG   = 6'b000010,
        PH_TOKEN  = 6'b000100,
        PH_OFF_LO = 6'b001000,
        PH_LEN    = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [31:0] exp_len_reg, exp_len_next;
    logic [31:0] blocks_reg, blocks_next;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  slot_reg, slot_next;
    logic [15:0] offset_reg, offset_next;
    logic [31:0] produced_reg, produced_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] room;
    logic [7:0]  n;
    logic        bad;
    logic        tok_end;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;

    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        exp_len_next  = exp_len_reg;
        blocks_next   = blocks_reg;
        flags_next    = flags_reg;
        slot_next     = slot_reg;
        offset_next   = offset_reg;
        produced_next = produced_reg;
        n             = '0;
        bad           = 1'b0;
        tok_end       = 1'b0;
        room          = exp_len_reg - produced_reg;

        case (phase_reg)
            PH_HEADER: begin
                if (hdr_idx_reg < 3'd4) begin
                    exp_len_next = {exp_len_reg[23:0], b};
                end else begin
                    blocks_next = {blocks_reg[23:0], b};
                end
                if (hdr_idx_reg == 3'(lzss_pkg::HEADER_LAST)) begin
                    hdr_idx_next = '0;
                    phase_next = (exp_len_next == '0 || blocks_next == '0) ? PH_DONE : PH_FLAG;
                end else begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                end
            end
            PH_FLAG: begin
                flags_next  = b;
                blocks_next = blocks_reg - 1'b1;
                slot_next   = '0;
                phase_next  = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flags_reg[slot_reg[2:0]]) begin
                    offset_next = {b, 8'h00};
                    phase_next  = PH_OFF_LO;
                end else begin
                    if (produced_reg < exp_len_reg) begin
                        n = 8'd1;
                    end
                    tok_end = 1'b1;
                end
            end
            PH_OFF_LO: begin
                offset_next = {offset_reg[15:8], b};
                phase_next  = PH_LEN;
            end
            PH_LEN: begin
                if (offset_reg == '0 || 32'(offset_reg) > produced_reg
                        || 32'(offset_reg) > 32'(HISTORY_DEPTH)) begin
                    bad = 1'b1;
                end else if (produced_reg < exp_len_reg) begin
                    n = (32'(b) < room) ? b : room[7:0];
                end
                tok_end = 1'b1;
            end
            default: begin
            end
        endcase

        produced_next = produced_reg + 32'(n);
        if (tok_end) begin
            slot_next = slot_reg + 1'b1;
            if (produced_next >= exp_len_reg) begin
                phase_next = PH_DONE;
            end else if (slot_next >= 4'(lzss_pkg::TOKENS_PER_BLOCK)) begin
                phase_next = (blocks_reg == '0) ? PH_DONE : PH_FLAG;
            end else begin
                phase_next = PH_TOKEN;
            end
        end
    end

    // Every word that yields bytes, a skipped match or end of stream becomes a command.
    assign cmd_push        = accept && (n != '0 || bad || s_data.end_of_stream);
    assign cmd_data.is_lit = (phase_reg == PH_TOKEN);
    assign cmd_data.lit    = b;
    assign cmd_data.off    = offset_reg;
    assign cmd_data.cnt    = n;
    assign cmd_data.bad    = bad;
    assign cmd_data.eos    = s_data.end_of_stream;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.end_of_stream)) begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= '0;
            exp_len_reg  <= '0;
            blocks_reg   <= '0;
            flags_reg    <= '0;
            slot_reg     <= '0;
            offset_reg   <= '0;
            produced_reg <= '0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            exp_len_reg  <= exp_len_next;
            blocks_reg   <= blocks_next;
            flags_reg    <= flags_next;
            slot_reg     <= slot_next;
            offset_reg   <= offset_next;
            produced_reg <= produced_next;
        end
    end

`ifndef SYNTHESIS
    a_within_length: assert property (@(posedge aclk) disable iff (!aresetn)
        produced_reg <= exp_len_reg)
        else $error("produced byte count passed the original length");
    a_bad_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push && cmd_data.bad |-> cmd_data.cnt == '0)
        else $error("skipped match carries bytes");
`endif

endmodule

// ===== hdl/lzss_back.sv =====
`timescale 1ns / 1ps
// Copy engine: runs commands against the history memory and packs result words.
module lzss_back #(
    parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_empty,
    input  lzss_pkg::cmd_t      cmd_head,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output lzss_pkg::out_word_t m_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int LW = $clog2(lzss_pkg::LANES);
    localparam int NW = $clog2(lzss_pkg::NEAR_WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DATA = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    lzss_pkg::cmd_t      cmd_reg;
    logic [7:0]          remain_reg, remain_next;
    logic [AW-1:0]       wptr_reg, wptr_next;
    logic [lzss_pkg::NEAR_WINDOW-1:0][7:0] recent_reg;
    logic [lzss_pkg::LANES-1:0][7:0]       pack_reg, pack_next;
    logic [LW-1:0]       pack_cnt_reg, pack_cnt_next;
    lzss_pkg::out_word_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                out_free;
    logic                near;
    logic                want_push, do_push, last_byte, emit_needed;
    logic                do_status, issue_rd;
    logic [7:0]          push_byte, rd_data;
    logic [lzss_pkg::LANES-1:0][7:0] new_word;
    logic [NW-1:0]       near_idx;
    logic [AW-1:0]       rd_addr;

    assign out_free    = !out_valid_reg || m_ready;
    assign near        = (cmd_reg.off <= 16'(lzss_pkg::NEAR_WINDOW));
    assign near_idx    = NW'(cmd_reg.off - 16'd1);
    assign last_byte   = (remain_reg == 8'd1);
    assign emit_needed = last_byte || (pack_cnt_reg == LW'(lzss_pkg::LANES - 1));
    assign rd_addr     = wptr_reg - cmd_reg.off[AW-1:0];

    assign want_push = ((state_reg == ST_RUN) && remain_reg != '0 && (cmd_reg.is_lit || near))
                       || (state_reg == ST_DATA);
    assign do_push   = want_push && (!emit_needed || out_free);
    assign do_status = (state_reg == ST_RUN) && remain_reg == '0 && out_free;
    assign issue_rd  = (state_reg == ST_RUN) && remain_reg != '0 && !cmd_reg.is_lit && !near;
    assign cmd_pop   = (state_reg == ST_IDLE) && !cmd_empty;

    always_comb begin
        if (state_reg == ST_DATA) begin
            push_byte = rd_data;
        end else if (cmd_reg.is_lit) begin
            push_byte = cmd_reg.lit;
        end else begin
            push_byte = recent_reg[near_idx];
        end
        new_word = pack_reg;
        new_word[pack_cnt_reg] = push_byte;
    end

    always_comb begin
        state_next     = state_reg;
        remain_next    = remain_reg;
        wptr_next      = wptr_reg;
        pack_next      = pack_reg;
        pack_cnt_next  = pack_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (!cmd_empty) begin
                    remain_next = cmd_head.cnt;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (do_status) begin
                    state_next = ST_IDLE;
                end else if (issue_rd) begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA: begin
                if (do_push) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_status) begin
            out_next.data_word   = '0;
            out_next.byte_count  = '0;
            out_next.run_last    = 1'b1;
            out_next.bad_match   = cmd_reg.bad;
            out_next.stream_done = cmd_reg.eos;
            out_valid_next       = 1'b1;
            if (cmd_reg.eos) begin
                wptr_next = '0;
            end
        end

        if (do_push) begin
            remain_next = remain_reg - 1'b1;
            wptr_next   = (last_byte && cmd_reg.eos) ? '0 : wptr_reg + 1'b1;
            if (last_byte) begin
                state_next = ST_IDLE;
            end
            if (emit_needed) begin
                out_next.data_word   = new_word;
                out_next.byte_count  = 3'(pack_cnt_reg) + 3'd1;
                out_next.run_last    = last_byte;
                out_next.bad_match   = 1'b0;
                out_next.stream_done = last_byte && cmd_reg.eos;
                out_valid_next       = 1'b1;
                pack_next            = '0;
                pack_cnt_next        = '0;
            end else begin
                pack_next     = new_word;
                pack_cnt_next = pack_cnt_reg + 1'b1;
            end
        end
    end

    lzss_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (do_push),
        .wr_addr (wptr_reg),
        .wr_data (push_byte),
        .rd_en   (issue_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            remain_reg    <= '0;
            wptr_reg      <= '0;
            pack_reg      <= '0;
            pack_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            remain_reg    <= remain_next;
            wptr_reg      <= wptr_next;
            pack_reg      <= pack_next;
            pack_cnt_reg  <= pack_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd_pop) begin
            cmd_reg <= cmd_head;
        end
        // shift every produced byte into the window that serves short offsets
        if (do_push) begin
            recent_reg <= {recent_reg[lzss_pkg::NEAR_WINDOW-2:0], push_byte};
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_status_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.byte_count == '0 |-> m_data.run_last
            && (m_data.bad_match || m_data.stream_done))
        else $error("empty result word without status");
    a_data_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DATA |-> $past(issue_rd) || $past(state_reg == ST_DATA))
        else $error("history data used without a read");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.byte_count <= 3'(lzss_pkg::LANES))
        else $error("result byte count out of range");
`endif

endmodule

// ===== hdl/lzss_stream_decompressor.sv =====
`timescale 1ns / 1ps
// Top level of the LZSS stream decompressor: parser, command queue, copy engine.
//
//  channel   direction  payload                  handshake
//  s_        in         in_word_t (byte, eos)    s_valid / s_ready
//  m_        out        out_word_t (up to 4 B)   m_valid / m_ready
//
// The parser takes one compressed byte per cycle while the command queue has room.
// The copy engine first pulls each command in its idle state, then writes one byte per cycle
// for literals and offsets up to 4 while no held result word stalls it; for longer offsets
// each byte takes a history read, then a write and pack; a status-only command yields one word.
// Reset is synchronous, active low, and clears all control state; the history memory
// needs no clearing. A held result word stalls the copy engine, a full queue the input.
module lzss_stream_decompressor #(
    parameter int HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzss_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lzss_pkg::out_word_t m_data
);

    logic           q_push, q_full, q_pop, q_empty;
    lzss_pkg::cmd_t q_in, q_head;

    lzss_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_push (q_push),
        .cmd_data (q_in),
        .cmd_full (q_full)
    );

    lzss_cmdq u_cmdq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    lzss_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (q_empty),
        .cmd_head  (q_head),
        .cmd_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
